[sv/ram_io_timer_array_assert.svh]
// assertion macros for the ram/io/timer block checker
`ifndef RAM_IO_TIMER_ARRAY_ASSERT_SVH
`define RAM_IO_TIMER_ARRAY_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RITA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define RITA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/rita_pkg.sv]
// shared types, codes and helpers of the ram/io/timer block
`timescale 1ns / 1ps
`default_nettype none

package rita_pkg;

   // item modes
   localparam logic [2:0] MODE_REG_READ  = 3'd0;
   localparam logic [2:0] MODE_REG_WRITE = 3'd1;
   localparam logic [2:0] MODE_RAM_READ  = 3'd2;
   localparam logic [2:0] MODE_RAM_WRITE = 3'd3;
   localparam logic [2:0] MODE_TICK      = 3'd4;
   localparam logic [2:0] MODE_PIN_UPD   = 3'd5;

   // port register select, address bits 1:0
   localparam logic [1:0] REG_PA_DATA = 2'd0;
   localparam logic [1:0] REG_PA_DIR  = 2'd1;
   localparam logic [1:0] REG_PB_DATA = 2'd2;
   localparam logic [1:0] REG_PB_DIR  = 2'd3;

   localparam int          TICKS_W      = 19;
   localparam logic [18:0] TICKS_RESET  = 19'd262144;
   localparam logic [18:0] TICKS_RELOAD = 19'd256;
   localparam logic [3:0]  SHIFT_RESET  = 4'd10;
   localparam logic [7:0]  PINS_RESET   = 8'hff;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] pa_drive;
      logic [7:0] pb_drive;
      logic       irq;
   } rita_result_type;

   // prescaler select to shift amount: 1, 8, 64, 1024
   function automatic logic [3:0] shift_of(input logic [1:0] sel);
      logic [3:0] s;
      unique case (sel)
         2'd0: s = 4'd0;
         2'd1: s = 4'd3;
         2'd2: s = 4'd6;
         2'd3: s = 4'd10;
         default: s = 4'd0;
      endcase
      return s;
   endfunction

   // ticks to the next expiry for a start value
   function automatic logic [18:0] start_ticks(input logic [7:0] value,
                                               input logic [3:0] shift);
      return 19'd1 + (19'(value) << shift);
   endfunction

endpackage

`default_nettype wire

[sv/rita_ram.sv]
// byte ram with one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module rita_ram #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data_ff
);

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[sv/rita_regs.sv]
// port, timer and edge detector registers with their read and write logic
`timescale 1ns / 1ps
`default_nettype none

module rita_regs (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      accept,
   input  wire logic [2:0]                mode,
   input  wire logic [6:0]                address,
   input  wire logic [7:0]                write_data,
   input  wire logic [7:0]                pa_pins,
   input  wire logic [7:0]                pb_pins,
   output rita_pkg::rita_result_type      result
);
   import rita_pkg::*;

   logic [7:0]  pa_latch_ff, pa_latch_in, pa_dir_ff, pa_dir_in;
   logic [7:0]  pb_latch_ff, pb_latch_in, pb_dir_ff, pb_dir_in;
   logic [7:0]  pa_pins_ff, pa_pins_in, pb_pins_ff, pb_pins_in;
   logic        pa7_prev_ff, pa7_prev_in;
   logic        edge_rise_ff, edge_rise_in, edge_ie_ff, edge_ie_in;
   logic        edge_flag_ff, edge_flag_in;
   logic        timer_ie_ff, timer_ie_in, timer_flag_ff, timer_flag_in;
   logic [18:0] ticks_ff, ticks_in;
   logic [3:0]  shift_ff, shift_in;
   logic        free_ff, free_in, jto_ff, jto_in;

   logic [3:0]  cur_shift;
   logic [18:0] shifted;
   logic        low_nz;
   logic [7:0]  timer_val;
   logic [7:0]  read_byte;
   logic        edge_check;
   logic [7:0]  pa_level;

   // current timer read value
   always_comb begin
      cur_shift = free_ff ? 4'd0 : shift_ff;
      shifted   = ticks_ff >> cur_shift;
      low_nz    = |(ticks_ff & ((19'd1 << cur_shift) - 19'd1));
      timer_val = low_nz ? shifted[7:0] : shifted[7:0] - 8'd1;
   end

   always_comb begin
      pa_latch_in   = pa_latch_ff;
      pa_dir_in     = pa_dir_ff;
      pb_latch_in   = pb_latch_ff;
      pb_dir_in     = pb_dir_ff;
      pa_pins_in    = pa_pins_ff;
      pb_pins_in    = pb_pins_ff;
      pa7_prev_in   = pa7_prev_ff;
      edge_rise_in  = edge_rise_ff;
      edge_ie_in    = edge_ie_ff;
      edge_flag_in  = edge_flag_ff;
      timer_ie_in   = timer_ie_ff;
      timer_flag_in = timer_flag_ff;
      ticks_in      = ticks_ff;
      shift_in      = shift_ff;
      free_in       = free_ff;
      jto_in        = jto_ff;
      read_byte     = 8'd0;
      edge_check    = 1'b0;
      pa_level      = 8'd0;

      if (accept) begin
         unique case (mode)
            MODE_REG_READ: begin
               if (!address[2]) begin
                  unique case (address[1:0])
                     REG_PA_DATA: read_byte = (pa_latch_ff & pa_dir_ff)
                                            | (pa_pins_ff & ~pa_dir_ff);
                     REG_PA_DIR:  read_byte = pa_dir_ff;
                     REG_PB_DATA: read_byte = (pb_latch_ff & pb_dir_ff)
                                            | (pb_pins_ff & ~pb_dir_ff);
                     REG_PB_DIR:  read_byte = pb_dir_ff;
                     default:     read_byte = 8'd0;
                  endcase
               end else if (!address[0]) begin
                  read_byte = timer_val;
                  // on the timeout tick the flag survives the read
                  if (!jto_ff) begin
                     timer_flag_in = 1'b0;
                     if (free_ff) begin
                        free_in  = 1'b0;
                        ticks_in = start_ticks(timer_val, shift_ff);
                     end
                  end
                  timer_ie_in = address[3];
               end else begin
                  read_byte    = {timer_flag_ff, edge_flag_ff, 6'd0};
                  edge_flag_in = 1'b0;
               end
            end
            MODE_REG_WRITE: begin
               if (!address[2]) begin
                  unique case (address[1:0])
                     REG_PA_DATA: begin
                        pa_latch_in = write_data;
                        edge_check  = 1'b1;
                     end
                     REG_PA_DIR: begin
                        pa_dir_in  = write_data;
                        edge_check = 1'b1;
                     end
                     REG_PB_DATA: pb_latch_in = write_data;
                     REG_PB_DIR:  pb_dir_in   = write_data;
                     default: ;
                  endcase
               end else if (address[4]) begin
                  shift_in      = shift_of(address[1:0]);
                  ticks_in      = start_ticks(write_data, shift_of(address[1:0]));
                  free_in       = 1'b0;
                  timer_flag_in = 1'b0;
                  timer_ie_in   = address[3];
               end else begin
                  edge_rise_in = address[0];
                  edge_ie_in   = address[1];
               end
            end
            MODE_TICK: begin
               if (ticks_ff <= 19'd1) begin
                  if (!free_ff) begin
                     timer_flag_in = 1'b1;
                     jto_in        = 1'b1;
                  end else begin
                     jto_in = 1'b0;
                  end
                  free_in  = 1'b1;
                  ticks_in = TICKS_RELOAD;
               end else begin
                  ticks_in = ticks_ff - 19'd1;
                  jto_in   = 1'b0;
               end
            end
            MODE_PIN_UPD: begin
               pa_pins_in = pa_pins;
               pb_pins_in = pb_pins;
               edge_check = 1'b1;
            end
            default: ;
         endcase

         // pa7 edge detector on the updated port a level
         if (edge_check) begin
            pa_level = (pa_latch_in & pa_dir_in) | (pa_pins_in & ~pa_dir_in);
            if (pa_level[7] != pa7_prev_ff && pa_level[7] == edge_rise_ff
                && !edge_flag_ff) begin
               edge_flag_in = 1'b1;
            end
            pa7_prev_in = pa_level[7];
         end
      end
   end

   always_comb begin
      result.read_data = read_byte;
      result.pa_drive  = (pa_latch_in & pa_dir_in) | ~pa_dir_in;
      result.pb_drive  = (pb_latch_in & pb_dir_in) | ~pb_dir_in;
      result.irq       = (timer_ie_in & timer_flag_in) | (edge_ie_in & edge_flag_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pa_latch_ff   <= 8'd0;
         pa_dir_ff     <= 8'd0;
         pb_latch_ff   <= 8'd0;
         pb_dir_ff     <= 8'd0;
         pa_pins_ff    <= PINS_RESET;
         pb_pins_ff    <= PINS_RESET;
         pa7_prev_ff   <= 1'b1;
         edge_rise_ff  <= 1'b0;
         edge_ie_ff    <= 1'b0;
         edge_flag_ff  <= 1'b0;
         timer_ie_ff   <= 1'b0;
         timer_flag_ff <= 1'b0;
         ticks_ff      <= TICKS_RESET;
         shift_ff      <= SHIFT_RESET;
         free_ff       <= 1'b0;
         jto_ff        <= 1'b0;
      end else begin
         pa_latch_ff   <= pa_latch_in;
         pa_dir_ff     <= pa_dir_in;
         pb_latch_ff   <= pb_latch_in;
         pb_dir_ff     <= pb_dir_in;
         pa_pins_ff    <= pa_pins_in;
         pb_pins_ff    <= pb_pins_in;
         pa7_prev_ff   <= pa7_prev_in;
         edge_rise_ff  <= edge_rise_in;
         edge_ie_ff    <= edge_ie_in;
         edge_flag_ff  <= edge_flag_in;
         timer_ie_ff   <= timer_ie_in;
         timer_flag_ff <= timer_flag_in;
         ticks_ff      <= ticks_in;
         shift_ff      <= shift_in;
         free_ff       <= free_in;
         jto_ff        <= jto_in;
      end
   end

endmodule

`default_nettype wire

[sv/ram_io_timer_array.sv]
// top level of the ram, i/o port and interval timer block
// usage:
//   req_* carries one item per handshake: register read or write, ram read or
//   write, one timer tick or a pin update (req_pa_pins/req_pb_pins sampled).
//   rsp_* returns exactly one item per request, in order: the byte read
//   (0 for items that read nothing), port drive levels and irq after the item.
//   an item is taken on a clock edge with valid high and stall low.
// pipeline and throughput:
//   accepted items pass the ram read stage, then the output register; one item
//   per cycle sustained while rsp_stall is low. the ram's registered read port is
//   read on the accept edge and its data enters the output register as s1 advances.
// reset:
//   synchronous, active high. ports clear to inputs, pins read as all ones,
//   timer starts at 255 with a 1024 prescale. ram contents stay undefined
//   until written, no clearing pass is made.
// back-pressure:
//   rsp_stall holds the output register; one more item may sit in the ram
//   read stage, after that req_stall rises. state updates happen on the
//   accept edge, so ram and register accesses keep request order.
`timescale 1ns / 1ps
`default_nettype none

module ram_io_timer_array #(
   parameter int RAM_BYTES = 128
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_mode,
   input  wire logic [6:0] req_address,
   input  wire logic [7:0] req_write_data,
   input  wire logic [7:0] req_pa_pins,
   input  wire logic [7:0] req_pb_pins,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_read_data,
   output logic [7:0]      rsp_pa_drive,
   output logic [7:0]      rsp_pb_drive,
   output logic            rsp_irq
);
   import rita_pkg::*;

   localparam int AW = $clog2(RAM_BYTES);

   logic            accept;
   logic            advance;
   logic [7:0]      addr_ext;
   logic [7:0]      addr_wrap;
   logic [AW-1:0]   ram_idx;
   logic            ram_rd;
   logic            ram_wr;
   logic [7:0]      ram_q;
   rita_result_type reg_res;

   // ram read stage
   logic            s1_valid_ff, s1_valid_in;
   logic            s1_ram_ff;
   rita_result_type s1_res_ff;
   rita_result_type s1_out;

   // output register
   logic            out_valid_ff, out_valid_in;
   rita_result_type out_res_ff;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // address modulo ram size, address stays below twice the size
   always_comb begin
      addr_ext  = {1'b0, req_address};
      addr_wrap = (addr_ext >= 8'(RAM_BYTES)) ? addr_ext - 8'(RAM_BYTES) : addr_ext;
      ram_idx   = addr_wrap[AW-1:0];
   end

   assign ram_rd = accept && (req_mode == MODE_RAM_READ);
   assign ram_wr = accept && (req_mode == MODE_RAM_WRITE);

   rita_ram #(
      .DEPTH (RAM_BYTES),
      .AW    (AW)
   ) u_ram (
      .clock      (clock),
      .wr_en      (ram_wr),
      .wr_addr    (ram_idx),
      .wr_data    (req_write_data),
      .rd_en      (ram_rd),
      .rd_addr    (ram_idx),
      .rd_data_ff (ram_q)
   );

   rita_regs u_regs (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .mode       (req_mode),
      .address    (req_address),
      .write_data (req_write_data),
      .pa_pins    (req_pa_pins),
      .pb_pins    (req_pb_pins),
      .result     (reg_res)
   );

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign out_valid_in = (s1_valid_ff && advance) || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // ram data is held since no new read happens while s1 waits
   always_comb begin
      s1_out = s1_res_ff;
      if (s1_ram_ff) begin
         s1_out.read_data = ram_q;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_res_ff <= reg_res;
         s1_ram_ff <= (req_mode == MODE_RAM_READ);
      end
      if (s1_valid_ff && advance) begin
         out_res_ff <= s1_out;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = out_res_ff.read_data;
   assign rsp_pa_drive  = out_res_ff.pa_drive;
   assign rsp_pb_drive  = out_res_ff.pb_drive;
   assign rsp_irq       = out_res_ff.irq;

endmodule

`default_nettype wire

[sv/rita_chk.sv]
// port-level checker for the ram/io/timer block and its bind
`timescale 1ns / 1ps
`default_nettype none

`include "ram_io_timer_array_assert.svh"

module rita_chk (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_read_data,
   input wire logic [7:0] rsp_pa_drive,
   input wire logic [7:0] rsp_pb_drive,
   input wire logic       rsp_irq
);

   // a new result rises only after an accepted item passed the ram read stage
   `RITA_ASSERT_NOW(a_rise_from_accept, $rose(rsp_valid), $past(req_valid && !req_stall, 2), "result without accepted item")

   // input back-pressure only comes from a stalled full output
   `RITA_ASSERT_NOW(a_stall_from_output, req_stall, rsp_valid && rsp_stall, "input stalled without output stall")

   // no result is pending right after reset
   `RITA_ASSERT_NOW(a_empty_after_reset, $fell(reset), !rsp_valid && !req_stall, "pipeline not empty after reset")

   // a stalled result holds
   `RITA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_read_data) && $stable(rsp_pa_drive) && $stable(rsp_pb_drive) && $stable(rsp_irq), "stalled result changed")

endmodule

bind ram_io_timer_array rita_chk u_rita_chk (.*);

`default_nettype wire

[sim/tb_top.sv]
// testbench for the ram, i/o port and interval timer block
`timescale 1ns / 1ps

module tb_top;
   import rita_pkg::*;

   localparam int RAM_DEPTH    = 128;
   localparam int RANDOM_ITEMS = 750;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_PRINTED  = 40;

   // mode codes the block treats as no-ops
   localparam logic [2:0] MODE_SPARE_6 = 3'd6;
   localparam logic [2:0] MODE_SPARE_7 = 3'd7;

   // register address bits, low five bits of the address
   localparam logic [4:0] A_SEL       = 5'b00011;  // port select, or prescale select
   localparam logic [4:0] A_FLAGS     = 5'b00001;  // on a read: flags instead of timer
   localparam logic [4:0] A_EDGE_RISE = 5'b00001;
   localparam logic [4:0] A_EDGE_IRQ  = 5'b00010;
   localparam logic [4:0] A_TIMER     = 5'b00100;
   localparam logic [4:0] A_IRQ_EN    = 5'b01000;
   localparam logic [4:0] A_TIMER_WR  = 5'b10000;

   // prescale shifts for select 0..3 (divide by 1, 8, 64, 1024), 4 bits each
   localparam logic [15:0] PRESCALE_SHIFTS = {4'd10, 4'd6, 4'd3, 4'd0};

   typedef struct packed {
      logic [2:0] mode;
      logic [6:0] addr;
      logic [7:0] wdata;
      logic [7:0] pa;
      logic [7:0] pb;
   } bus_access_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_type;

   // dut connections, all inputs known from time zero
   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [2:0] req_mode       = 3'd0;
   logic [6:0] req_address    = 7'd0;
   logic [7:0] req_write_data = 8'd0;
   logic [7:0] req_pa_pins    = 8'd0;
   logic [7:0] req_pb_pins    = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [7:0] rsp_read_data;
   logic [7:0] rsp_pa_drive;
   logic [7:0] rsp_pb_drive;
   logic       rsp_irq;

   // items waiting to be driven, and replies the chip owes
   bus_access_type  bus_accesses [$];
   rita_result_type replies_due  [$];

   // generator view of which ram bytes have been written
   bit         ram_written [RAM_DEPTH];
   logic [6:0] ram_written_list [$];
   int         stim_count = 0;

   int mismatch_count = 0;
   bit req_fire       = 1'b0;

   // image of the chip state, updated in acceptance order
   logic [7:0]         ram_image [RAM_DEPTH];
   logic [7:0]         pa_latch = 8'h00, pa_dir = 8'h00;
   logic [7:0]         pb_latch = 8'h00, pb_dir = 8'h00;
   logic [7:0]         pa_pins_q = PINS_RESET, pb_pins_q = PINS_RESET;
   logic               pa7_last = 1'b1;
   logic               edge_rise_sel = 1'b0, edge_irq_en = 1'b0, edge_flag_q = 1'b0;
   logic               tmr_irq_en = 1'b0, tmr_flag = 1'b0;
   logic               free_run = 1'b0, just_expired = 1'b0;
   logic [TICKS_W-1:0] ticks_left = TICKS_RESET;
   logic [3:0]         pre_shift = SHIFT_RESET;

   ram_io_timer_array #(
      .RAM_BYTES(RAM_DEPTH)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_address   (req_address),
      .req_write_data(req_write_data),
      .req_pa_pins   (req_pa_pins),
      .req_pb_pins   (req_pb_pins),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_read_data (rsp_read_data),
      .rsp_pa_drive  (rsp_pa_drive),
      .rsp_pb_drive  (rsp_pb_drive),
      .rsp_irq       (rsp_irq)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // chip image
   // ------------------------------------------------------------------

   // level seen on a port: latch where the bit is an output, pin where input
   function automatic logic [7:0] port_level(input logic [7:0] latch, input logic [7:0] dir,
                                             input logic [7:0] pins);
      return (latch & dir) | (pins & ~dir);
   endfunction

   // pa7 edge detector, flag only sets from clear on the selected direction
   function automatic void sense_pa7();
      logic [7:0] lvl;
      lvl = port_level(pa_latch, pa_dir, pa_pins_q);
      if (lvl[7] != pa7_last && lvl[7] == edge_rise_sel && !edge_flag_q)
         edge_flag_q = 1'b1;
      pa7_last = lvl[7];
   endfunction

   // start counting from value at the current prescale
   function automatic void load_timer(input logic [7:0] value);
      ticks_left = 19'd1 + (19'(value) << pre_shift);
      free_run   = 1'b0;
   endfunction

   // apply one item to the image and return the reply it produces
   function automatic rita_result_type chip_reply_for(input bus_access_type acc);
      rita_result_type    r;
      logic [4:0]         a;
      logic [3:0]         s;
      logic [7:0]         v;
      logic [TICKS_W-1:0] shifted;
      a = acc.addr[4:0];
      r = '0;
      case (acc.mode)
         MODE_REG_READ: begin
            if (!a[2]) begin
               case (a[1:0])
                  REG_PA_DATA: r.read_data = port_level(pa_latch, pa_dir, pa_pins_q);
                  REG_PA_DIR:  r.read_data = pa_dir;
                  REG_PB_DATA: r.read_data = port_level(pb_latch, pb_dir, pb_pins_q);
                  default:     r.read_data = pb_dir;
               endcase
            end else if (!a[0]) begin
               // timer read: count shown one less when the prescale phase is zero
               s = free_run ? 4'd0 : pre_shift;
               shifted = ticks_left >> s;
               v = shifted[7:0];
               if ((ticks_left & ((19'd1 << s) - 19'd1)) == 19'd0)
                  v = v - 8'd1;
               // on the expiry tick the read leaves flag and free running alone
               if (!just_expired) begin
                  tmr_flag = 1'b0;
                  if (free_run)
                     load_timer(v);
               end
               tmr_irq_en  = a[3];
               r.read_data = v;
            end else begin
               r.read_data = {tmr_flag, edge_flag_q, 6'd0};
               edge_flag_q = 1'b0;
            end
         end
         MODE_REG_WRITE: begin
            if (!a[2]) begin
               case (a[1:0])
                  REG_PA_DATA: begin
                     pa_latch = acc.wdata;
                     sense_pa7();
                  end
                  REG_PA_DIR: begin
                     pa_dir = acc.wdata;
                     sense_pa7();
                  end
                  REG_PB_DATA: pb_latch = acc.wdata;
                  default:     pb_dir = acc.wdata;
               endcase
            end else if (a[4]) begin
               pre_shift = PRESCALE_SHIFTS[a[1:0]*4 +: 4];
               load_timer(acc.wdata);
               tmr_flag   = 1'b0;
               tmr_irq_en = a[3];
            end else begin
               edge_rise_sel = a[0];
               edge_irq_en   = a[1];
            end
         end
         MODE_RAM_READ:  r.read_data = ram_image[acc.addr % RAM_DEPTH];
         MODE_RAM_WRITE: ram_image[acc.addr % RAM_DEPTH] = acc.wdata;
         MODE_TICK: begin
            if (ticks_left <= 19'd1) begin
               // expiry: flag only when coming out of counting mode
               if (!free_run) begin
                  tmr_flag     = 1'b1;
                  just_expired = 1'b1;
               end else begin
                  just_expired = 1'b0;
               end
               free_run   = 1'b1;
               ticks_left = TICKS_RELOAD;
            end else begin
               ticks_left   = ticks_left - 19'd1;
               just_expired = 1'b0;
            end
         end
         MODE_PIN_UPD: begin
            pa_pins_q = acc.pa;
            pb_pins_q = acc.pb;
            sense_pa7();
         end
         default: ;
      endcase
      r.pa_drive = (pa_latch & pa_dir) | ~pa_dir;
      r.pb_drive = (pb_latch & pb_dir) | ~pb_dir;
      r.irq      = (tmr_irq_en & tmr_flag) | (edge_irq_en & edge_flag_q);
      return r;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   // random address with the care bits of the low five forced to val
   function automatic logic [6:0] mix_addr(input logic [4:0] care, input logic [4:0] val);
      logic [6:0] r;
      r = 7'($urandom);
      r[4:0] = (r[4:0] & ~care) | (val & care);
      return r;
   endfunction

   // ram reads only ever land on written bytes; with none written, write instead
   task automatic add_access(input logic [2:0] mode, input logic [6:0] addr,
                             input logic [7:0] wdata, input logic [7:0] pa,
                             input logic [7:0] pb);
      bus_access_type acc;
      acc.mode  = mode;
      acc.addr  = addr;
      acc.wdata = wdata;
      acc.pa    = pa;
      acc.pb    = pb;
      if (acc.mode == MODE_RAM_READ && !ram_written[acc.addr % RAM_DEPTH]) begin
         if (ram_written_list.size() != 0)
            acc.addr = ram_written_list[$urandom_range(0, ram_written_list.size() - 1)];
         else
            acc.mode = MODE_RAM_WRITE;
      end
      if (acc.mode == MODE_RAM_WRITE && !ram_written[acc.addr % RAM_DEPTH]) begin
         ram_written[acc.addr % RAM_DEPTH] = 1'b1;
         ram_written_list.push_back(acc.addr);
      end
      bus_accesses.push_back(acc);
      if (acc.mode <= MODE_PIN_UPD)
         stim_count++;
   endtask

   // item with random data and pins
   task automatic queue_access(input logic [2:0] mode, input logic [6:0] addr);
      add_access(mode, addr, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // background traffic that never writes the timer
   task automatic add_side_access();
      case ($urandom_range(0, 5))
         0: queue_access(MODE_REG_READ, mix_addr(A_TIMER | A_FLAGS, A_TIMER));
         1: queue_access(MODE_REG_READ, mix_addr(A_TIMER | A_FLAGS, A_TIMER | A_FLAGS));
         2: queue_access(MODE_REG_READ, mix_addr(A_TIMER, 5'd0));
         3: queue_access(MODE_RAM_READ, 7'($urandom));
         4: queue_access(MODE_PIN_UPD, 7'($urandom));
         default: queue_access(MODE_REG_WRITE, mix_addr(A_TIMER, 5'd0));
      endcase
   endtask

   task automatic log_mismatch(input string what);
      if (mismatch_count < MAX_PRINTED)
         $display("%0t mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------
   // stimulus and run control
   // ------------------------------------------------------------------
   initial begin : stimulus
      int base, n, i, k, sel, value, shift;
      bit wild;

      // directed: reset values, ram extremes, ports, edge detector, timer expiry
      add_access(MODE_REG_READ, 7'(A_TIMER), 8'hff, 8'h00, 8'hff);  // 255 after reset
      add_access(MODE_REG_READ, 7'(A_TIMER | A_FLAGS), 8'h00, 8'hff, 8'h00);
      add_access(MODE_RAM_WRITE, 7'h00, 8'h00, 8'h00, 8'h00);
      add_access(MODE_RAM_WRITE, 7'h7f, 8'hff, 8'hff, 8'hff);
      add_access(MODE_RAM_READ, 7'h7f, 8'h00, 8'h00, 8'h00);
      // pa7 falls as pa turns to output with latch 0: falling edge flag
      add_access(MODE_REG_WRITE, 7'(REG_PA_DIR), 8'hff, 8'h00, 8'h00);
      add_access(MODE_REG_WRITE, 7'(REG_PA_DATA), 8'h80, 8'h00, 8'h00);
      add_access(MODE_REG_WRITE, 7'(REG_PB_DATA), 8'ha5, 8'h00, 8'h00);
      add_access(MODE_REG_WRITE, 7'(REG_PB_DIR), 8'h0f, 8'h00, 8'h00);
      add_access(MODE_REG_READ, {2'b11, 5'(REG_PB_DATA)}, 8'hff, 8'hff, 8'hff);
      // rising select with irq, edge flag already up
      add_access(MODE_REG_WRITE, 7'(A_TIMER | A_EDGE_RISE | A_EDGE_IRQ), 8'h00, 8'h00, 8'h00);
      add_access(MODE_REG_READ, 7'(A_TIMER | A_FLAGS | A_IRQ_EN), 8'h00, 8'h00, 8'h00);
      add_access(MODE_REG_WRITE, 7'(REG_PA_DIR), 8'h00, 8'h00, 8'h00);
      add_access(MODE_PIN_UPD, 7'h00, 8'h00, 8'h00, 8'hff);  // fall, ignored
      add_access(MODE_PIN_UPD, 7'h00, 8'h00, 8'h80, 8'h00);  // rise, flags
      // prescale 1 from 2 with irq: expires on the third tick
      add_access(MODE_REG_WRITE, 7'(A_TIMER_WR | A_TIMER | A_IRQ_EN), 8'h02, 8'h00, 8'h00);
      for (i = 0; i < 3; i++)
         add_access(MODE_TICK, 7'h00, 8'h00, 8'h00, 8'h00);
      // read on the expiry tick keeps the flag, the next one clears and reloads
      add_access(MODE_REG_READ, 7'(A_TIMER | A_IRQ_EN), 8'h00, 8'h00, 8'h00);
      add_access(MODE_TICK, 7'h00, 8'h00, 8'h00, 8'h00);
      add_access(MODE_REG_READ, 7'(A_TIMER), 8'h00, 8'h00, 8'h00);
      // largest start at divide by 1024
      add_access(MODE_REG_WRITE, {2'b11, A_TIMER_WR | A_TIMER | A_SEL}, 8'hff, 8'h00, 8'h00);
      add_access(MODE_REG_READ, 7'(A_TIMER), 8'h00, 8'h00, 8'h00);
      add_access(MODE_SPARE_6, 7'h7f, 8'hff, 8'hff, 8'hff);
      add_access(MODE_SPARE_7, 7'h00, 8'h00, 8'h00, 8'h00);
      add_access(MODE_REG_WRITE, 7'(A_TIMER), 8'h00, 8'h00, 8'h00);  // edge control back to 0

      // random part, mostly well-formed episodes with random content
      base = stim_count;
      while (stim_count - base < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               // timer episode: program, tick to around expiry, read back
               k = $urandom_range(0, 19);
               if (k < 8)
                  sel = 0;
               else if (k < 15)
                  sel = 1;
               else if (k < 18)
                  sel = 2;
               else
                  sel = 3;
               case (sel)
                  0: value = $urandom_range(0, 24);
                  1: value = $urandom_range(0, 4);
                  2: value = $urandom_range(0, 1);
                  default: value = 0;
               endcase
               // now and then any start value and prescale, only a few ticks
               wild = ($urandom_range(0, 9) == 0);
               if (wild) begin
                  sel   = $urandom_range(0, 3);
                  value = $urandom_range(0, 255);
               end
               shift = PRESCALE_SHIFTS[sel*4 +: 4];
               queue_access(MODE_REG_WRITE, mix_addr(A_TIMER_WR | A_TIMER | A_SEL,
                                                      A_TIMER_WR | A_TIMER | 5'(sel)));
               bus_accesses[$].wdata = 8'(value);
               if (wild)
                  n = $urandom_range(0, 6);
               else
                  n = (value << shift) + $urandom_range(0, 4);
               // rarely run on through a free-running wrap
               if (!wild && $urandom_range(0, 19) == 0)
                  n += 258;
               for (i = 0; i < n; i++) begin
                  queue_access(MODE_TICK, 7'($urandom));
                  if ($urandom_range(0, 7) == 0)
                     add_side_access();
               end
               if ($urandom_range(0, 1))
                  queue_access(MODE_REG_READ, mix_addr(A_TIMER | A_FLAGS, A_TIMER));
               if ($urandom_range(0, 1)) begin
                  n = $urandom_range(0, 3);
                  for (i = 0; i < n; i++)
                     queue_access(MODE_TICK, 7'($urandom));
                  queue_access(MODE_REG_READ, mix_addr(A_TIMER | A_FLAGS, A_TIMER));
               end
               queue_access(MODE_REG_READ, mix_addr(A_TIMER | A_FLAGS, A_TIMER | A_FLAGS));
            end
            4, 5: begin
               // port episode: latches, directions, pins and read back
               n = $urandom_range(3, 8);
               for (i = 0; i < n; i++) begin
                  case ($urandom_range(0, 3))
                     0: queue_access(MODE_REG_WRITE, mix_addr(A_TIMER | A_SEL, 5'($urandom)));
                     1: queue_access(MODE_REG_READ, mix_addr(A_TIMER | A_SEL, 5'($urandom)));
                     2: queue_access(MODE_PIN_UPD, 7'($urandom));
                     default: begin
                        k = $urandom_range(0, 1);
                        add_access(MODE_REG_WRITE,
                                   mix_addr(A_TIMER | A_SEL,
                                            k ? 5'(REG_PB_DIR) : 5'(REG_PA_DIR)),
                                   $urandom_range(0, 1) ? 8'hff : 8'h00,
                                   8'($urandom), 8'($urandom));
                     end
                  endcase
               end
            end
            6: begin
               // edge episode: pick direction and irq, then move pa7 around
               queue_access(MODE_REG_WRITE, mix_addr(A_TIMER_WR | A_TIMER, A_TIMER));
               n = $urandom_range(3, 8);
               for (i = 0; i < n; i++) begin
                  case ($urandom_range(0, 4))
                     0, 1: queue_access(MODE_PIN_UPD, 7'($urandom));
                     2: queue_access(MODE_REG_WRITE,
                                     mix_addr(A_TIMER | A_SEL, 5'(REG_PA_DATA)));
                     3: queue_access(MODE_REG_WRITE,
                                     mix_addr(A_TIMER | A_SEL, 5'(REG_PA_DIR)));
                     default: queue_access(MODE_REG_READ,
                                           mix_addr(A_TIMER | A_FLAGS, A_TIMER | A_FLAGS));
                  endcase
               end
               queue_access(MODE_REG_READ, mix_addr(A_TIMER | A_FLAGS, A_TIMER | A_FLAGS));
            end
            7, 8: begin
               // ram episode
               n = $urandom_range(2, 8);
               for (i = 0; i < n; i++)
                  queue_access($urandom_range(0, 1) ? MODE_RAM_WRITE : MODE_RAM_READ,
                               7'($urandom));
            end
            default: begin
               // noise: any mode, spare ones included
               n = $urandom_range(1, 4);
               for (i = 0; i < n; i++)
                  queue_access(3'($urandom_range(0, 7)), 7'($urandom));
            end
         endcase
      end

      // one reset, released away from the driving edge
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all items taken, every reply back, then a short drain
      while (bus_accesses.size() != 0 || req_valid)
         @(negedge clock);
      while (replies_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0 && replies_due.size() == 0)
         $display("** ram_io_timer_array: PASSED **");
      else
         $display("** ram_io_timer_array: FAILED **");
      $finish;
   end

   // ------------------------------------------------------------------
   // request driver: bursts of items with random gaps, changes on falling edge
   // ------------------------------------------------------------------
   int             burst_left = 1;
   int             idle_gap   = 0;
   bus_access_type next_access;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         // a stalled item stays put; only move on once it was taken
         if (idle_gap > 0) begin
            idle_gap = idle_gap - 1;
            req_valid <= 1'b0;
         end else if (bus_accesses.size() != 0) begin
            next_access = bus_accesses.pop_front();
            req_valid      <= 1'b1;
            req_mode       <= next_access.mode;
            req_address    <= next_access.addr;
            req_write_data <= next_access.wdata;
            req_pa_pins    <= next_access.pa;
            req_pb_pins    <= next_access.pb;
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
               // a third of the bursts run straight into the next one
               burst_left = $urandom_range(1, 30);
               idle_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // reply stall: the style is picked anew each time its random period runs out
   // ------------------------------------------------------------------
   stall_style_type stall_style = STALL_NONE;
   int              stall_left  = 0;
   int              stall_phase = 0;

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_style = stall_style_type'($urandom_range(0, 3));
         stall_left  = $urandom_range(20, 120);
      end else begin
         stall_left = stall_left - 1;
      end
      stall_phase = stall_phase + 1;
      case (stall_style)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= (stall_phase % 3 != 0);
      endcase
   end

   // ------------------------------------------------------------------
   // monitor: predict on request acceptance, check on reply acceptance
   // ------------------------------------------------------------------
   bus_access_type  seen_access;
   rita_result_type due_reply;

   always @(posedge clock) begin
      if (reset) begin
         req_fire = 1'b0;
      end else begin
         req_fire = req_valid && !req_stall;
         if (req_fire) begin
            seen_access.mode  = req_mode;
            seen_access.addr  = req_address;
            seen_access.wdata = req_write_data;
            seen_access.pa    = req_pa_pins;
            seen_access.pb    = req_pb_pins;
            replies_due.push_back(chip_reply_for(seen_access));
         end
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               log_mismatch("reply with no item outstanding");
            end else begin
               due_reply = replies_due.pop_front();
               if (rsp_read_data !== due_reply.read_data)
                  log_mismatch($sformatf("read_data %02h, expected %02h",
                                         rsp_read_data, due_reply.read_data));
               if (rsp_pa_drive !== due_reply.pa_drive)
                  log_mismatch($sformatf("pa_drive %02h, expected %02h",
                                         rsp_pa_drive, due_reply.pa_drive));
               if (rsp_pb_drive !== due_reply.pb_drive)
                  log_mismatch($sformatf("pb_drive %02h, expected %02h",
                                         rsp_pb_drive, due_reply.pb_drive));
               if (rsp_irq !== due_reply.irq)
                  log_mismatch($sformatf("irq %0b, expected %0b", rsp_irq, due_reply.irq));
            end
         end
      end
   end

   // watchdog: too long with nothing moving on either channel
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("** ram_io_timer_array: FAILED **");
         $finish;
      end
   end

endmodule
